>>> hdl/frgg_pkg.sv
// shared types and constants for the filtered record ring with gaps
// no dependencies; the front, queue, back, top level and testbench import this package
package frgg_pkg;

  // ring geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int ACT_W  = 3;
  localparam int TYPE_W = 4;
  localparam int SEC_W  = 32;
  localparam int MS_W   = 10;
  localparam int PAY_W  = 64;
  localparam int MASK_W = 15;
  localparam int DROP_W = 16;
  localparam int SPAN_W = 32;

  // action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_RECORD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_COMMIT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ARM    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DISARM = 3'd4;

  localparam logic [TYPE_W-1:0] GAP_TYPE        = 4'd15;
  localparam logic [MASK_W-1:0] TYPE_MASK_RESET = 15'h7FFF;
  localparam logic [DROP_W-1:0] DROP_MAX        = 16'hFFFF;
  localparam logic [SPAN_W-1:0] SPAN_MAX        = 32'hFFFF_FFFF;
  localparam logic signed [10:0] MS_PER_S       = 11'sd1000;

  // classified command kinds
  typedef enum logic [2:0] {
    K_NOP    = 3'd0,
    K_RECORD = 3'd1,
    K_PEEK   = 3'd2,
    K_COMMIT = 3'd3,
    K_ARM    = 3'd4,
    K_DISARM = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [TYPE_W-1:0] rec_type;
    logic [SEC_W-1:0]  seconds;
    logic [MS_W-1:0]   millis;
    logic [PAY_W-1:0]  payload;
  } cmd_t;

  // one ring entry: meta and payload side by side
  typedef struct packed {
    logic [TYPE_W-1:0] rec_type;
    logic [SEC_W-1:0]  seconds;
    logic [MS_W-1:0]   millis;
    logic [PAY_W-1:0]  payload;
  } ring_word_t;

  typedef struct packed {
    logic              ok;
    logic [TYPE_W-1:0] out_type;
    logic [SEC_W-1:0]  out_seconds;
    logic [MS_W-1:0]   out_millis;
    logic [PAY_W-1:0]  out_payload;
  } res_t;

  // status of the back end, watched at the top level
  typedef struct packed {
    logic             armed;
    logic [CNT_W-1:0] cnt;
  } stat_t;

endpackage

>>> hdl/frgg_if.sv
// valid/ready channel interfaces for the input actions and the results
// field widths follow the record format; no package dependency
interface frgg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [3:0]  rec_type;
  logic [31:0] rec_seconds;
  logic [9:0]  rec_millis;
  logic [63:0] rec_payload;

  modport source (output valid, action, rec_type, rec_seconds, rec_millis, rec_payload,
                  input ready);
  modport sink   (input valid, action, rec_type, rec_seconds, rec_millis, rec_payload,
                  output ready);
endinterface

interface frgg_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [3:0]  out_type;
  logic [31:0] out_seconds;
  logic [9:0]  out_millis;
  logic [63:0] out_payload;

  modport source (output valid, ok, out_type, out_seconds, out_millis, out_payload,
                  input ready);
  modport sink   (input valid, ok, out_type, out_seconds, out_millis, out_payload,
                  output ready);
endinterface

>>> hdl/frgg_front.sv
// front end: takes input beats, holds the type mask and classifies each action
// depends on frgg_pkg and frgg_in_if
module frgg_front (
  input  logic                       clk,
  input  logic                       rst,
  frgg_in_if.sink                    rec_in,
  input  logic                       cfg_we,
  input  logic [frgg_pkg::MASK_W-1:0] cfg_wdata,
  output logic                       push_valid,
  output frgg_pkg::cmd_t             push_cmd,
  input  logic                       push_ready
);
  import frgg_pkg::*;

  logic [MASK_W-1:0] type_mask;
  logic [MASK_W:0]   mask_ext;
  logic              type_kept;

  // type mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      type_mask <= TYPE_MASK_RESET;
    end else if (cfg_we) begin
      type_mask <= cfg_wdata;
    end
  end

  // gap type has no mask bit and is never kept
  assign mask_ext  = {1'b0, type_mask};
  assign type_kept = mask_ext[rec_in.rec_type];

  // classify the beat
  always_comb begin
    push_cmd.rec_type = rec_in.rec_type;
    push_cmd.seconds  = rec_in.rec_seconds;
    push_cmd.millis   = rec_in.rec_millis;
    push_cmd.payload  = rec_in.rec_payload;
    unique case (rec_in.action)
      ACT_RECORD: push_cmd.kind = type_kept ? K_RECORD : K_NOP;
      ACT_PEEK:   push_cmd.kind = K_PEEK;
      ACT_COMMIT: push_cmd.kind = K_COMMIT;
      ACT_ARM:    push_cmd.kind = K_ARM;
      ACT_DISARM: push_cmd.kind = K_DISARM;
      default:    push_cmd.kind = K_NOP;
    endcase
  end

  assign push_valid   = rec_in.valid;
  assign rec_in.ready = push_ready;

endmodule

>>> hdl/frgg_queue.sv
// short command queue that decouples the front end from the back end
// depends on frgg_pkg
module frgg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  frgg_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output frgg_pkg::cmd_t pop_cmd,
  input  logic           pop
);
  import frgg_pkg::*;

  cmd_t               slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != Q_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> hdl/frgg_back.sv
// back end: ring memory, drop bookkeeping, gap record insertion and result register
// depends on frgg_pkg and frgg_out_if
module frgg_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  frgg_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  frgg_out_if.source      res_out,
  output frgg_pkg::stat_t stat
);
  import frgg_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIFF  = 6'b000010,
    S_MUL   = 6'b000100,
    S_FLUSH = 6'b001000,
    S_EXEC  = 6'b010000,
    S_READ  = 6'b100000
  } state_t;

  state_t             state;
  cmd_t               cmd_r;
  logic               armed;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [DROP_W-1:0]  total_dropped;
  logic [DROP_W-1:0]  gap_dropped;
  logic [SEC_W-1:0]   gap_first_seconds;
  logic [MS_W-1:0]    gap_first_millis;
  logic [SEC_W-1:0]   gap_last_seconds;
  logic [MS_W-1:0]    gap_last_millis;
  logic signed [32:0] ds_r;
  logic signed [10:0] md_r;
  logic signed [43:0] prod_r;
  res_t               res_r;
  logic               res_valid;

  ring_word_t         ring [CAPACITY];
  ring_word_t         rd_word;
  ring_word_t         wr_word;
  logic               wr_en;
  logic               rd_en;
  logic [IDX_W-1:0]   tail;
  logic [SUM_W-1:0]   tail_sum;
  logic [IDX_W-1:0]   head_inc;
  logic               full;
  logic               gap_pending;
  logic               res_take;
  logic               res_free;
  logic signed [43:0] span_sum;
  logic [SPAN_W-1:0]  span;

  // ring addressing
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign tail     = (tail_sum >= SUM_W'(CAPACITY)) ? IDX_W'(tail_sum - SUM_W'(CAPACITY))
                                                    : IDX_W'(tail_sum);
  assign head_inc = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + 1'b1;
  assign full        = (count == CNT_W'(CAPACITY));
  assign gap_pending = (gap_dropped != '0) && !full;

  // result register handshake
  assign res_take = res_valid && res_out.ready;
  assign res_free = !res_valid || res_out.ready;
  assign q_pop    = (state == S_IDLE) && q_valid && res_free;

  // gap span: clamp at zero, saturate at the top
  always_comb begin
    span_sum = prod_r + {{33{md_r[10]}}, md_r};
    if (span_sum[43] || span_sum == '0) begin
      span = '0;
    end else if (span_sum[42:32] != '0) begin
      span = SPAN_MAX;
    end else begin
      span = span_sum[31:0];
    end
  end

  // memory write selection
  always_comb begin
    wr_en = (state == S_FLUSH) || (state == S_EXEC && cmd_r.kind == K_RECORD && !full);
    rd_en = (state == S_EXEC) && (cmd_r.kind == K_PEEK) && (count != '0);
    if (state == S_FLUSH) begin
      wr_word.rec_type = GAP_TYPE;
      wr_word.seconds  = gap_first_seconds;
      wr_word.millis   = gap_first_millis;
      wr_word.payload  = {span, gap_dropped, total_dropped};
    end else begin
      wr_word.rec_type = cmd_r.rec_type;
      wr_word.seconds  = cmd_r.seconds;
      wr_word.millis   = cmd_r.millis;
      wr_word.payload  = cmd_r.payload;
    end
  end

  // ring memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[tail] <= wr_word;
    end
    if (rd_en) begin
      rd_word <= ring[head];
    end
  end

  // sequencer and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      armed             <= 1'b0;
      head              <= '0;
      count             <= '0;
      total_dropped     <= '0;
      gap_dropped       <= '0;
      gap_first_seconds <= '0;
      gap_first_millis  <= '0;
      gap_last_seconds  <= '0;
      gap_last_millis   <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (res_take) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_cmd;
            unique case (q_cmd.kind)
              K_RECORD: begin
                if (!armed) begin
                  res_r     <= '0;
                  res_valid <= 1'b1;
                end else begin
                  state <= gap_pending ? S_DIFF : S_EXEC;
                end
              end
              K_PEEK: begin
                state <= gap_pending ? S_DIFF : S_EXEC;
              end
              K_COMMIT: begin
                if (count != '0) begin
                  head  <= head_inc;
                  count <= count - 1'b1;
                end
                res_r     <= '0;
                res_valid <= 1'b1;
              end
              K_ARM: begin
                if (!armed) begin
                  head          <= '0;
                  count         <= '0;
                  total_dropped <= '0;
                  gap_dropped   <= '0;
                  armed         <= 1'b1;
                end
                res_r     <= '0;
                res_valid <= 1'b1;
              end
              K_DISARM: begin
                armed     <= 1'b0;
                res_r     <= '0;
                res_valid <= 1'b1;
              end
              default: begin
                res_r     <= '0;
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_DIFF: begin
          ds_r  <= $signed({1'b0, gap_last_seconds}) - $signed({1'b0, gap_first_seconds});
          md_r  <= $signed({1'b0, gap_last_millis}) - $signed({1'b0, gap_first_millis});
          state <= S_MUL;
        end
        S_MUL: begin
          prod_r <= ds_r * MS_PER_S;
          state  <= S_FLUSH;
        end
        S_FLUSH: begin
          count       <= count + 1'b1;
          gap_dropped <= '0;
          state       <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd_r.kind == K_RECORD) begin
            if (full) begin
              // note the drop for the next gap record
              if (gap_dropped == '0) begin
                gap_first_seconds <= cmd_r.seconds;
                gap_first_millis  <= cmd_r.millis;
              end
              gap_last_seconds <= cmd_r.seconds;
              gap_last_millis  <= cmd_r.millis;
              if (gap_dropped != DROP_MAX) begin
                gap_dropped <= gap_dropped + 1'b1;
              end
              if (total_dropped != DROP_MAX) begin
                total_dropped <= total_dropped + 1'b1;
              end
              res_r <= '0;
            end else begin
              count <= count + 1'b1;
              // stored: ok set, every other field zero
              res_r <= {1'b1, {($bits(res_t) - 1){1'b0}}};
            end
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (count == '0) begin
            res_r     <= '0;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          res_r.ok          <= 1'b1;
          res_r.out_type    <= rd_word.rec_type;
          res_r.out_seconds <= rd_word.seconds;
          res_r.out_millis  <= rd_word.millis;
          res_r.out_payload <= rd_word.payload;
          res_valid         <= 1'b1;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign res_out.valid       = res_valid;
  assign res_out.ok          = res_r.ok;
  assign res_out.out_type    = res_r.out_type;
  assign res_out.out_seconds = res_r.out_seconds;
  assign res_out.out_millis  = res_r.out_millis;
  assign res_out.out_payload = res_r.out_payload;

  assign stat.armed = armed;
  assign stat.cnt   = count;

endmodule

>>> hdl/filtered_record_ring_with_gaps.sv
// Filtered trace ring with gap records.
// rec_in carries one action per beat (record, peek, commit, arm, disarm);
// res_out returns exactly one result beat per action, in order. cfg_we and
// cfg_wdata write the 15-bit type mask; the user must do so only while the
// block is idle, which the block itself does not enforce. The front end
// classifies each beat and places it in a two-entry command queue; the back
// end sequencer runs one command at a time against a 64-entry ring memory
// with a registered read port. Commit, arm, disarm, ignored records and
// unknown actions are answered from the idle state; a stored or dropped
// record or a peek of an empty ring from the execute state, and a peek that
// finds an entry from the read state after it. A pending gap record is
// first flushed by difference, multiply by 1000, clamp and write.
// Reset leaves the block disarmed with an empty ring and the mask all ones;
// ring contents are not cleared.
// If res_out is stalled, the result stays in its output register; the back
// end holds its next command and the queue keeps taking beats until full.
// depends on frgg_pkg, frgg_if, frgg_front, frgg_queue and frgg_back
module filtered_record_ring_with_gaps (
  input  logic                        clk,
  input  logic                        rst,
  frgg_in_if.sink                     rec_in,
  frgg_out_if.source                  res_out,
  input  logic                        cfg_we,
  input  logic [frgg_pkg::MASK_W-1:0] cfg_wdata
);
  import frgg_pkg::*;

  logic  push_valid;
  logic  push_ready;
  cmd_t  push_cmd;
  logic  pop_valid;
  cmd_t  pop_cmd;
  logic  pop;
  stat_t stat;

  // classification and mask
  frgg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rec_in     (rec_in),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // command queue
  frgg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  // ring and result
  frgg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_cmd   (pop_cmd),
    .q_pop   (pop),
    .res_out (res_out),
    .stat    (stat)
  );

  // ring never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    stat.cnt <= CNT_W'(CAPACITY))
    else $error("ring fill above capacity");

  // fill moves by one per cycle, or drops to zero on arming
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (stat.cnt != $past(stat.cnt)) |->
      (stat.cnt == $past(stat.cnt) + 1'b1 || stat.cnt == $past(stat.cnt) - 1'b1 ||
       stat.cnt == '0))
    else $error("ring fill jumped");

  // a peeked gap record always reports at least one drop
  a_gap_count: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.ok && res_out.out_type == GAP_TYPE) |->
      (res_out.out_payload[31:16] != '0))
    else $error("gap record with zero drop count");

endmodule

>>> tb/tb_filtered_record_ring_with_gaps.sv
`timescale 1ns / 100ps
// self-checking testbench for the filtered trace ring with gap records
// depends on frgg_pkg, frgg_if and filtered_record_ring_with_gaps
module tb_filtered_record_ring_with_gaps;
  import frgg_pkg::*;

  // spare action codes that the block must ignore
  localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  localparam logic [MASK_W-1:0] MASK_NONE = '0;
  localparam logic [PAY_W-1:0]  PAY_ONES  = '1;
  localparam logic [SEC_W-1:0]  SEC_ONES  = '1;
  localparam logic [MS_W-1:0]   MS_ONES   = '1;

  // directed rows: ok value typed in, or left to the ring model
  localparam int BY_MODEL = -1;
  localparam int OK_NO    = 0;
  localparam int OK_YES   = 1;

  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 200;
  // drops in one long gap before space frees
  localparam int GAP_DROPS      = 40;

  typedef enum int {TS_STEADY, TS_SCATTER, TS_BACKWARD} stamp_mode_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [TYPE_W-1:0] rec_type;
    logic [SEC_W-1:0]  rec_seconds;
    logic [MS_W-1:0]   rec_millis;
    logic [PAY_W-1:0]  rec_payload;
  } beat_t;

  typedef struct {
    beat_t b;
    int    want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  frgg_in_if  rec_ch ();
  frgg_out_if res_ch ();

  filtered_record_ring_with_gaps DUT (
    .clk       (clk),
    .rst       (rst),
    .rec_in    (rec_ch),
    .res_out   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ring model state
  logic              ring_armed;
  int unsigned       ring_head;
  int unsigned       ring_fill;
  logic [DROP_W-1:0] drops_total;
  logic [DROP_W-1:0] drops_in_gap;
  logic [SEC_W-1:0]  gap_first_sec;
  logic [MS_W-1:0]   gap_first_ms;
  logic [SEC_W-1:0]  gap_last_sec;
  logic [MS_W-1:0]   gap_last_ms;
  logic [MASK_W-1:0] kept_types;
  ring_word_t        ring_words [CAPACITY];

  res_t awaited_results [$];
  row_t directed_rows [$];

  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_req;
  stamp_mode_t stamp_mode;
  logic [SEC_W-1:0] stamp_clock;

  int beats_in;
  int counted_items;
  int results_seen = 0;
  int gap_peeks    = 0;
  int mask_writes;
  int mismatches   = 0;
  int stall_cycles = 0;

  // ring model: append one entry at the tail
  function automatic void ring_append(input ring_word_t w);
    ring_words[IDX_W'((ring_head + ring_fill) % CAPACITY)] = w;
    ring_fill++;
  endfunction

  // ring model: store the pending gap record if there is one and room for it
  function automatic void store_pending_gap();
    longint     span;
    longint     first_ms;
    longint     last_ms;
    longint     span_cap;
    ring_word_t w;
    if (drops_in_gap == '0 || ring_fill >= CAPACITY) return;
    first_ms = gap_first_sec;
    last_ms  = gap_last_sec;
    span_cap = SPAN_MAX;
    span = (last_ms - first_ms) * MS_PER_S + longint'(gap_last_ms) - longint'(gap_first_ms);
    if (span <= 0) span = 0;
    else if (span > span_cap) span = span_cap;
    w.rec_type = GAP_TYPE;
    w.seconds  = gap_first_sec;
    w.millis   = gap_first_ms;
    w.payload  = {span[SPAN_W-1:0], drops_in_gap, drops_total};
    drops_in_gap = '0;
    ring_append(w);
  endfunction

  // ring model: one action in, the result it produces out
  function automatic res_t trace_ring_step(input beat_t b, output bit ignored);
    res_t r;
    r = '0;
    ignored = 1'b0;
    case (b.action)
      ACT_RECORD: begin
        if (!ring_armed || b.rec_type == GAP_TYPE || !kept_types[b.rec_type]) begin
          ignored = 1'b1;
        end else begin
          store_pending_gap();
          if (ring_fill >= CAPACITY) begin
            if (drops_in_gap == '0) begin
              gap_first_sec = b.rec_seconds;
              gap_first_ms  = b.rec_millis;
            end
            gap_last_sec = b.rec_seconds;
            gap_last_ms  = b.rec_millis;
            if (drops_in_gap != DROP_MAX) drops_in_gap++;
            if (drops_total != DROP_MAX) drops_total++;
          end else begin
            ring_append({b.rec_type, b.rec_seconds, b.rec_millis, b.rec_payload});
            r.ok = 1'b1;
          end
        end
      end
      ACT_PEEK: begin
        store_pending_gap();
        if (ring_fill != 0) r = {1'b1, ring_words[IDX_W'(ring_head)]};
      end
      ACT_COMMIT: begin
        if (ring_fill != 0) begin
          ring_head = (ring_head + 1) % CAPACITY;
          ring_fill--;
        end
      end
      ACT_ARM: begin
        if (!ring_armed) begin
          ring_head    = 0;
          ring_fill    = 0;
          drops_total  = '0;
          drops_in_gap = '0;
          ring_armed   = 1'b1;
        end
      end
      ACT_DISARM: ring_armed = 1'b0;
      default: ignored = 1'b1;
    endcase
    return r;
  endfunction

  // a type that the mask keeps, most of the time
  function automatic logic [TYPE_W-1:0] pick_type();
    logic [TYPE_W-1:0] t;
    t = TYPE_W'($urandom_range(0, 15));
    if (kept_types != MASK_NONE && $urandom_range(0, 9) != 0) begin
      while (t == GAP_TYPE || !kept_types[t]) t = TYPE_W'($urandom_range(0, 14));
    end
    return t;
  endfunction

  function automatic beat_t make_beat(input logic [ACT_W-1:0] a);
    beat_t b;
    case (stamp_mode)
      TS_STEADY:   stamp_clock += $urandom_range(0, 2);
      TS_BACKWARD: stamp_clock -= $urandom_range(0, 2);
      default:     stamp_clock = $urandom;
    endcase
    b.action      = a;
    b.rec_type    = pick_type();
    b.rec_seconds = stamp_clock;
    b.rec_millis  = MS_W'($urandom_range(0, 1023));
    b.rec_payload = {$urandom, $urandom};
    return b;
  endfunction

  function automatic void add_row(input logic [ACT_W-1:0] a, input logic [TYPE_W-1:0] t,
                                  input logic [SEC_W-1:0] s, input logic [MS_W-1:0] m,
                                  input logic [PAY_W-1:0] p, input int want);
    row_t row;
    row.b    = {a, t, s, m, p};
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // offer one beat, wait for the handshake, then record what must come back
  task automatic send_beat(input beat_t b, input int want);
    int   gap;
    bit   ignored;
    res_t r;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      rec_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rec_ch.valid       <= 1'b1;
    rec_ch.action      <= b.action;
    rec_ch.rec_type    <= b.rec_type;
    rec_ch.rec_seconds <= b.rec_seconds;
    rec_ch.rec_millis  <= b.rec_millis;
    rec_ch.rec_payload <= b.rec_payload;
    do @(posedge clk); while (!rec_ch.ready);
    r = trace_ring_step(b, ignored);
    if (want != BY_MODEL) begin
      r = '0;
      r.ok = (want == OK_YES);
    end
    awaited_results.push_back(r);
    beats_in++;
    if (!ignored) counted_items++;
    @(negedge clk);
  endtask

  // sender stops until every awaited result is back and the block is quiet
  task automatic drain_results();
    rec_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] v);
    drain_results();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    kept_types = v;
    mask_writes++;
  endtask

  // random traffic made of arm-and-fill runs, mixed actions and noise
  task automatic run_random(input int items);
    int goal;
    int n;
    int pick;
    goal = beats_in + items;
    while (beats_in < goal) begin
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0:       stamp_mode = TS_SCATTER;
        1:       stamp_mode = TS_BACKWARD;
        default: stamp_mode = TS_STEADY;
      endcase
      if (pick < 5) begin
        // fill to near or past capacity, then work the head while records keep coming
        if (ring_armed) send_beat(make_beat(ACT_DISARM), BY_MODEL);
        send_beat(make_beat(ACT_ARM), BY_MODEL);
        n = $urandom_range(CAPACITY - 4, CAPACITY + 24);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send_beat(make_beat(ACT_PEEK), BY_MODEL);
          else send_beat(make_beat(ACT_RECORD), BY_MODEL);
        end
        n = $urandom_range(10, 50);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: send_beat(make_beat(ACT_COMMIT), BY_MODEL);
            4, 5, 6:    send_beat(make_beat(ACT_PEEK), BY_MODEL);
            default:    send_beat(make_beat(ACT_RECORD), BY_MODEL);
          endcase
        end
      end else if (pick < 8) begin
        n = $urandom_range(10, 30);
        repeat (n) begin
          case ($urandom_range(0, 19))
            0:       send_beat(make_beat(ACT_ARM), BY_MODEL);
            1:       send_beat(make_beat(ACT_DISARM), BY_MODEL);
            2, 3, 4, 5, 6:     send_beat(make_beat(ACT_PEEK), BY_MODEL);
            7, 8, 9, 10, 11:   send_beat(make_beat(ACT_COMMIT), BY_MODEL);
            default: send_beat(make_beat(ACT_RECORD), BY_MODEL);
          endcase
        end
      end else begin
        // any action code, any type, any timestamp
        n = $urandom_range(5, 15);
        repeat (n) begin
          beat_t b;
          b = make_beat(ACT_W'($urandom_range(0, 7)));
          b.rec_type    = TYPE_W'($urandom_range(0, 15));
          b.rec_seconds = $urandom;
          send_beat(b, BY_MODEL);
        end
      end
    end
  endtask

  // long receiver stall while the sender keeps offering beats
  task automatic back_pressure_burst();
    hold_req = 1'b1;
    stamp_mode = TS_STEADY;
    repeat (12) send_beat(make_beat(ACT_RECORD), BY_MODEL);
  endtask

  task automatic check_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t mismatch %s: expected %h, got %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // result checker: each result beat against the oldest awaited one
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.ok && res_ch.out_type == GAP_TYPE) gap_peeks++;
      if (awaited_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t unexpected result beat: expected none, got ok %b type %h",
                   $time, res_ch.ok, res_ch.out_type);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("ok", 64'(want.ok), 64'(res_ch.ok));
        check_field("out_type", 64'(want.out_type), 64'(res_ch.out_type));
        check_field("out_seconds", 64'(want.out_seconds), 64'(res_ch.out_seconds));
        check_field("out_millis", 64'(want.out_millis), 64'(res_ch.out_millis));
        check_field("out_payload", want.out_payload, res_ch.out_payload);
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin : watchdog
    if (rst || (rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t no beat moved for %0d cycles", $time, stall_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result receiver: random stalls, or one long hold when asked
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // stimulus
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    rec_ch.valid       = 1'b0;
    rec_ch.action      = ACT_RECORD;
    rec_ch.rec_type    = '0;
    rec_ch.rec_seconds = '0;
    rec_ch.rec_millis  = '0;
    rec_ch.rec_payload = '0;
    hold_req      = 1'b0;
    tx_idle_pct   = 14;
    rx_idle_pct   = 58;
    stamp_mode    = TS_STEADY;
    stamp_clock   = 32'h0001_0000;
    beats_in      = 0;
    counted_items = 0;
    mask_writes   = 0;

    ring_armed   = 1'b0;
    ring_head    = 0;
    ring_fill    = 0;
    drops_total  = '0;
    drops_in_gap = '0;
    gap_first_sec = '0;
    gap_first_ms  = '0;
    gap_last_sec  = '0;
    gap_last_ms   = '0;
    kept_types    = TYPE_MASK_RESET;

    // directed table: empty ring, disarmed, spare codes, extremes, peek after disarm
    add_row(ACT_PEEK,    4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_RECORD,  4'd3,     32'd5,    10'd7,   64'hA5,      OK_NO);
    add_row(ACT_COMMIT,  4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_SPARE_5, 4'd1,     SEC_ONES, MS_ONES, PAY_ONES,    OK_NO);
    add_row(ACT_SPARE_6, 4'd2,     32'd9,    10'd9,   64'h1234,    OK_NO);
    add_row(ACT_SPARE_7, GAP_TYPE, SEC_ONES, MS_ONES, PAY_ONES,    OK_NO);
    add_row(ACT_DISARM,  4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_ARM,     4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_ARM,     4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_RECORD,  GAP_TYPE, 32'd100,  10'd1,   PAY_ONES,    OK_NO);
    add_row(ACT_RECORD,  4'd0,     '0,       '0,      '0,          OK_YES);
    add_row(ACT_RECORD,  4'd14,    SEC_ONES, MS_ONES, PAY_ONES,    OK_YES);
    add_row(ACT_PEEK,    4'd0,     '0,       '0,      '0,          BY_MODEL);
    add_row(ACT_COMMIT,  4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_PEEK,    4'd0,     '0,       '0,      '0,          BY_MODEL);
    add_row(ACT_DISARM,  4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_RECORD,  4'd7,     32'd77,   10'd999, 64'h5A5A,    OK_NO);
    add_row(ACT_PEEK,    4'd0,     '0,       '0,      '0,          BY_MODEL);
    add_row(ACT_COMMIT,  4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_PEEK,    4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_ARM,     4'd0,     '0,       '0,      '0,          OK_NO);
    add_row(ACT_RECORD,  4'd9,     32'd1,    10'd1000, 64'h8000_0000_0000_0001, OK_YES);
    add_row(ACT_PEEK,    4'd0,     '0,       '0,      '0,          BY_MODEL);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // phase one: sender idles a little, receiver a lot
    foreach (directed_rows[i]) send_beat(directed_rows[i].b, directed_rows[i].want);
    write_mask(MASK_W'($urandom_range(1, 32766)));
    run_random(200);
    back_pressure_burst();
    run_random(200);

    // phase two: roles swapped; first every type masked off
    tx_idle_pct = 58;
    rx_idle_pct = 14;
    write_mask(MASK_NONE);
    run_random(50);
    write_mask(TYPE_MASK_RESET);
    run_random(200);
    write_mask(MASK_W'($urandom_range(1, 32766)));
    run_random(200);

    // phase three: no idling at all
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_mask(MASK_W'($urandom_range(1, 32766)));
    run_random(250);

    // one long gap of drops, then free space and flush it
    write_mask(TYPE_MASK_RESET);
    stamp_mode = TS_STEADY;
    if (ring_armed) send_beat(make_beat(ACT_DISARM), BY_MODEL);
    send_beat(make_beat(ACT_ARM), BY_MODEL);
    repeat (CAPACITY + GAP_DROPS) send_beat(make_beat(ACT_RECORD), BY_MODEL);
    send_beat(make_beat(ACT_COMMIT), BY_MODEL);
    send_beat(make_beat(ACT_PEEK), BY_MODEL);
    send_beat(make_beat(ACT_RECORD), BY_MODEL);
    send_beat(make_beat(ACT_COMMIT), BY_MODEL);
    send_beat(make_beat(ACT_RECORD), BY_MODEL);
    send_beat(make_beat(ACT_PEEK), BY_MODEL);

    drain_results();
    $display("summary: %0d beats sent (%0d with effect), %0d results checked",
             beats_in, counted_items, results_seen);
    $display("summary: %0d gap records peeked, %0d mask writes, %0d mismatches",
             gap_peeks, mask_writes, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/frgg_pkg.sv
hdl/frgg_if.sv
hdl/frgg_front.sv
hdl/frgg_queue.sv
hdl/frgg_back.sv
hdl/filtered_record_ring_with_gaps.sv
tb/tb_filtered_record_ring_with_gaps.sv
